FILE: design/vao_pkg.sv
// shared constants, types and state encoding for the oldest-steal voice allocator
// no dependencies
`default_nettype none

package vao_pkg;

	localparam int VOICES      = 8;
	localparam int VOICE_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int MAX_REPORT  = 8;
	localparam int N_REPORT    = (VOICES < MAX_REPORT) ? VOICES : MAX_REPORT;

	localparam int OP_W        = 2;
	localparam int KEY_W       = 7;
	localparam int TIME_W      = 48;
	localparam int ACT_W       = 2;
	localparam int OUT_VOICE_W = 3;

	// opcodes
	localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_ALL_OFF = 2'd2;

	// result actions
	localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_START   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

	localparam logic [KEY_W-1:0] KEY_LIMIT = 7'h53;

	// a held voice counts as released at a time past every stamp
	localparam logic [TIME_W:0] NEVER_RELEASED = {1'b1, {TIME_W{1'b0}}};

	localparam logic [VOICE_W-1:0] LAST_IDX   = VOICE_W'(VOICES - 1);
	localparam logic [VOICE_W-1:0] REPORT_END = VOICE_W'(N_REPORT - 1);

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] press;
		logic [TIME_W-1:0] rel;
		logic              held;
	} vao_voice_t;

	typedef struct packed {
		logic              start;
		logic              stop;
		logic              clear_key;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now;
	} vao_edit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} vao_state_t;

endpackage

`default_nettype wire

FILE: design/vao_if.sv
// event and result channel interfaces of the voice allocator
// depends on vao_pkg
`default_nettype none

interface vao_evt_if import vao_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [KEY_W-1:0]  note_key;
	logic [TIME_W-1:0] now;

	modport source (output valid, opcode, note_key, now, input ready);
	modport sink (input valid, opcode, note_key, now, output ready);
endinterface

interface vao_res_if import vao_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [ACT_W-1:0]       action;
	logic [OUT_VOICE_W-1:0] voice;
	logic [KEY_W-1:0]       voice_key;
	logic                   last;

	modport source (output valid, action, voice, voice_key, last, input ready);
	modport sink (input valid, action, voice, voice_key, last, output ready);
endinterface

`default_nettype wire

FILE: design/vao_cell.sv
// one voice cell of the rotating ring: holds key, press and release stamps, held flag
// depends on vao_pkg
`default_nettype none

module vao_cell import vao_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire vao_voice_t state_in,
	input  wire vao_edit_t  edit,
	output vao_voice_t      cur_q
);

	vao_voice_t nxt;

	always_comb begin
		nxt = state_in;
		if (edit.stop) begin
			nxt.held = 1'b0;
			nxt.rel  = edit.now;
			if (edit.clear_key) begin
				nxt.key = '0;
			end
		end
		if (edit.start) begin
			nxt.key   = edit.key;
			nxt.press = edit.now;
			nxt.held  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (shift) begin
			cur_q <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: design/voice_allocator_oldest_steal.sv
// press: one scan round, one write round, then the finish state loads the result
// release: one scan round, then the finish state; all notes off: one scan round, one result
// per reported voice; high key press or undefined opcode: straight to the finish state
// the ring of voice cells rotates one place a cycle past a single compare unit (all notes off
// stalls on the result side); next word accepted the cycle after the last result is loaded
// arst_n clears all voices (key 0, stamps 0, not held) and sets release_mode to 1
`default_nettype none

module voice_allocator_oldest_steal import vao_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire logic   cfg_wdata,
	vao_evt_if.sink     evt,
	vao_res_if.source   res
);

	// ---------------------------------------------------------------
	// control and item registers
	// ---------------------------------------------------------------
	vao_state_t          state_q, state_nxt;
	logic                mode_q;          // release mode register
	logic [VOICE_W-1:0]  idx_q;           // voice currently at the head of the ring
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [TIME_W-1:0]   now_q;
	logic                found_q;         // key match seen earlier in this turn
	logic                nothing_q;       // press of a key already held
	logic [VOICE_W-1:0]  pick_q;          // steal candidate so far
	logic [TIME_W:0]     pick_rel_q;
	logic [TIME_W-1:0]   pick_press_q;
	logic [ACT_W-1:0]    act_q;           // pending single result
	logic [VOICE_W-1:0]  voice_q;
	logic [KEY_W-1:0]    rkey_q;

	// output register, parts the result side from the ring
	logic                   o_valid_q;
	logic [ACT_W-1:0]       o_act_q;
	logic [OUT_VOICE_W-1:0] o_voice_q;
	logic [KEY_W-1:0]       o_key_q;
	logic                   o_last_q;

	// ---------------------------------------------------------------
	// ring of voice cells, head at cell 0, edited word enters the tail
	// ---------------------------------------------------------------
	vao_voice_t chain_q [VOICES];
	vao_voice_t head;
	vao_edit_t  edit;
	logic       step_en;

	assign head = chain_q[0];

	for (genvar j = 0; j < VOICES; j++) begin : g_ring
		if (j == VOICES - 1) begin : g_tail
			vao_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (step_en),
				.state_in (head),
				.edit     (edit),
				.cur_q    (chain_q[j])
			);
		end else begin : g_body
			vao_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (step_en),
				.state_in (chain_q[j+1]),
				.edit     ('0),
				.cur_q    (chain_q[j])
			);
		end
	end

	// ---------------------------------------------------------------
	// compare unit on the head voice
	// ---------------------------------------------------------------
	logic [TIME_W:0]   head_eff;
	logic              take_new;
	logic              key_hit;
	logic [ACT_W-1:0]  end_act;
	logic              can_load;
	logic              at_last;
	logic              emit;

	assign head_eff = head.held ? NEVER_RELEASED : {1'b0, head.rel};
	// released longer ago wins, ties to the earlier press, then lower index
	assign take_new = (pick_rel_q > head_eff) ||
		((pick_rel_q == head_eff) && (pick_press_q > head.press));
	assign key_hit  = (head.key == key_q);
	assign end_act  = mode_q ? ACT_RELEASE : ACT_CLEAR;
	assign can_load = !o_valid_q || res.ready;
	assign at_last  = (idx_q == LAST_IDX);
	assign emit     = (idx_q <= REPORT_END);

	assign evt.ready = (state_q == ST_IDLE);

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (evt.valid) begin
					case (evt.opcode)
						OP_PRESS: begin
							state_nxt = (evt.note_key >= KEY_LIMIT) ? ST_FINISH : ST_SCAN;
						end
						OP_RELEASE, OP_ALL_OFF: begin
							state_nxt = ST_SCAN;
						end
						default: begin
							state_nxt = ST_FINISH;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (step_en && at_last) begin
					case (op_q)
						OP_PRESS:   state_nxt = ST_WRITE;
						OP_RELEASE: state_nxt = ST_FINISH;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_WRITE: begin
				if (at_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (can_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// ring shift, cell edit and result load
	// ---------------------------------------------------------------
	logic                   load;
	logic [ACT_W-1:0]       ld_act;
	logic [OUT_VOICE_W-1:0] ld_voice;
	logic [KEY_W-1:0]       ld_key;
	logic                   ld_last;

	always_comb begin
		step_en        = 1'b0;
		edit           = '0;
		edit.clear_key = !mode_q;
		edit.key       = key_q;
		edit.now       = now_q;
		load           = 1'b0;
		ld_act         = ACT_NONE;
		ld_voice       = '0;
		ld_key         = '0;
		ld_last        = 1'b0;
		case (state_q)
			ST_SCAN: begin
				case (op_q)
					OP_PRESS: begin
						step_en = 1'b1;
					end
					OP_RELEASE: begin
						// first held voice with the key is ended
						step_en   = 1'b1;
						edit.stop = !found_q && key_hit && head.held;
					end
					default: begin
						// all notes off: one word per reported voice, stalls on the result side
						step_en   = !emit || can_load;
						edit.stop = head.held;
						load      = emit && can_load;
						ld_last   = (idx_q == REPORT_END);
						if (head.held) begin
							ld_act   = end_act;
							ld_voice = OUT_VOICE_W'(idx_q);
							ld_key   = mode_q ? head.key : '0;
						end
					end
				endcase
			end
			ST_WRITE: begin
				step_en    = 1'b1;
				edit.start = !nothing_q && (idx_q == pick_q);
			end
			ST_FINISH: begin
				load    = can_load;
				ld_act  = act_q;
				ld_last = 1'b1;
				if (act_q != ACT_NONE) begin
					ld_voice = OUT_VOICE_W'(voice_q);
					ld_key   = rkey_q;
				end
			end
			default: begin
				step_en = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= 1'b1;
			idx_q   <= '0;
			found_q <= 1'b0;
			nothing_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (step_en) begin
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
			if (evt.valid && evt.ready) begin
				found_q   <= 1'b0;
				nothing_q <= 1'b0;
			end else if (state_q == ST_SCAN && !found_q) begin
				if (op_q == OP_PRESS && key_hit) begin
					found_q <= 1'b1;
					if (head.held) begin
						nothing_q <= 1'b1;
					end
				end else if (op_q == OP_RELEASE && key_hit && head.held) begin
					found_q <= 1'b1;
				end
			end
			if (load) begin
				o_valid_q <= 1'b1;
			end else if (res.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// item payload, steal candidate and pending result
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			op_q   <= evt.opcode;
			key_q  <= evt.note_key;
			now_q  <= evt.now;
			act_q  <= ACT_NONE;
			voice_q <= '0;
			rkey_q <= '0;
		end
		if (state_q == ST_SCAN && op_q == OP_PRESS && !found_q) begin
			// a released voice still carrying the key is reused
			if (idx_q == '0 || take_new || (key_hit && !head.held)) begin
				pick_q <= idx_q;
			end
			if (idx_q == '0 || take_new) begin
				pick_rel_q   <= head_eff;
				pick_press_q <= head.press;
			end
		end
		if (state_q == ST_SCAN && op_q == OP_RELEASE && !found_q && key_hit && head.held) begin
			act_q   <= end_act;
			voice_q <= idx_q;
			rkey_q  <= mode_q ? head.key : '0;
		end
		if (state_q == ST_WRITE && at_last) begin
			act_q   <= nothing_q ? ACT_NONE : ACT_START;
			voice_q <= pick_q;
			rkey_q  <= key_q;
		end
		if (load) begin
			o_act_q   <= ld_act;
			o_voice_q <= ld_voice;
			o_key_q   <= ld_key;
			o_last_q  <= ld_last;
		end
	end

	assign res.valid     = o_valid_q;
	assign res.action    = o_act_q;
	assign res.voice     = o_voice_q;
	assign res.voice_key = o_key_q;
	assign res.last      = o_last_q;

`ifndef SYNTHESIS
	// the ring is back in its home position whenever no item is in flight
	a_home_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (idx_q == '0))
		else $error("ring not aligned in idle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("head index out of range");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |=> (state_q != ST_IDLE))
		else $error("accepted word did not start work");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.action == ACT_NONE) |-> (res.voice == '0 && res.voice_key == '0))
		else $error("nothing result carries voice data");
`endif

endmodule

`default_nettype wire

FILE: verif/voice_allocator_oldest_steal_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the oldest-steal voice allocator: directed and random note events
// checked word by word against a predictor of the voice table
// depends on vao_pkg, vao_if and voice_allocator_oldest_steal

module voice_allocator_oldest_steal_tb;
	import vao_pkg::*;

	// opcode 3 has no meaning and must leave the voice table alone
	localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS    = 82;
	localparam int TAIL_START     = 40;

	// one result word as the block presents it
	typedef struct packed {
		logic [ACT_W-1:0]       action;
		logic [OUT_VOICE_W-1:0] voice;
		logic [KEY_W-1:0]       voice_key;
		logic                   last;
	} alloc_word_t;

	// voice table predictor and the store of result words still to come
	class voice_table_scoreboard;
		logic [KEY_W-1:0]  key_of[VOICES];
		logic [TIME_W-1:0] pressed_at[VOICES];
		logic [TIME_W-1:0] released_at[VOICES];
		bit                held[VOICES];
		bit                envelope_mode;
		alloc_word_t       due_words[$];
		int                bad_words;

		function new();
			for (int i = 0; i < VOICES; i++) begin
				key_of[i] = '0;
				pressed_at[i] = '0;
				released_at[i] = '0;
				held[i] = 1'b0;
			end
			envelope_mode = 1'b1;
			bad_words = 0;
		endfunction

		function void push_word(logic [ACT_W-1:0] act, int v, logic [KEY_W-1:0] key, bit fin);
			alloc_word_t w;
			w.action = act;
			w.voice = (act == ACT_NONE) ? '0 : OUT_VOICE_W'(v);
			w.voice_key = (act == ACT_NONE) ? '0 : key;
			w.last = fin;
			due_words.push_back(w);
		endfunction

		// a held voice ranks as released after every possible stamp
		function logic [TIME_W:0] release_rank(int i);
			return held[i] ? NEVER_RELEASED : {1'b0, released_at[i]};
		endfunction

		function logic [ACT_W-1:0] end_voice(int i, logic [TIME_W-1:0] stamp);
			logic [ACT_W-1:0] act;
			if (envelope_mode) begin
				act = ACT_RELEASE;
			end else begin
				key_of[i] = '0;
				act = ACT_CLEAR;
			end
			released_at[i] = stamp;
			held[i] = 1'b0;
			return act;
		endfunction

		function void start_note(logic [KEY_W-1:0] key, logic [TIME_W-1:0] stamp);
			int pick;
			bit reuse;
			logic [TIME_W:0] rank_pick, rank_i;
			pick = 0;
			reuse = 1'b0;
			if (key >= KEY_LIMIT) begin
				push_word(ACT_NONE, 0, '0, 1'b1);
				return;
			end
			for (int i = 0; i < VOICES && !reuse; i++) begin
				rank_pick = release_rank(pick);
				rank_i = release_rank(i);
				if (rank_pick > rank_i || (rank_pick == rank_i && pressed_at[pick] > pressed_at[i]))
					pick = i;
				if (key_of[i] == key) begin
					if (held[i]) begin
						push_word(ACT_NONE, 0, '0, 1'b1);
						return;
					end
					pick = i;
					reuse = 1'b1;
				end
			end
			key_of[pick] = key;
			pressed_at[pick] = stamp;
			held[pick] = 1'b1;
			push_word(ACT_START, pick, key, 1'b1);
		endfunction

		function void stop_note(logic [KEY_W-1:0] key, logic [TIME_W-1:0] stamp);
			bit found;
			logic [ACT_W-1:0] act;
			found = 1'b0;
			for (int i = 0; i < VOICES && !found; i++) begin
				if (key_of[i] == key && held[i]) begin
					act = end_voice(i, stamp);
					push_word(act, i, key_of[i], 1'b1);
					found = 1'b1;
				end
			end
			if (!found)
				push_word(ACT_NONE, 0, '0, 1'b1);
		endfunction

		function void note_event(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
				logic [TIME_W-1:0] stamp);
			logic [ACT_W-1:0] act;
			case (op)
				OP_PRESS: begin
					start_note(key, stamp);
				end
				OP_RELEASE: begin
					stop_note(key, stamp);
				end
				OP_ALL_OFF: begin
					for (int i = 0; i < VOICES; i++) begin
						act = ACT_NONE;
						if (held[i])
							act = end_voice(i, stamp);
						if (i < N_REPORT)
							push_word(act, i, key_of[i], i == N_REPORT - 1);
					end
				end
				default: begin
					push_word(ACT_NONE, 0, '0, 1'b1);
				end
			endcase
		endfunction

		function void note_bad(string why, alloc_word_t want, alloc_word_t got);
			bad_words++;
			if (bad_words <= 10)
				$display("%0t %s: want act %0d voice %0d key %0d last %0d, got act %0d voice %0d key %0d last %0d",
					$realtime, why, want.action, want.voice, want.voice_key, want.last,
					got.action, got.voice, got.voice_key, got.last);
		endfunction

		function void check_result(alloc_word_t got);
			alloc_word_t want;
			if (due_words.size() == 0) begin
				note_bad("unexpected word", '0, got);
				return;
			end
			want = due_words.pop_front();
			if (want !== got)
				note_bad("wrong word", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	vao_evt_if evt_ch ();
	vao_res_if res_ch ();

	voice_allocator_oldest_steal u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.evt       (evt_ch),
		.res       (res_ch)
	);

	voice_table_scoreboard sb;

	// shared between the stimulus and the receiver
	bit hold_request = 1'b0;   // ask the receiver for one long stall
	bit quiet_tail = 1'b0;     // no idling on either side from here on
	logic [TIME_W-1:0] frame = '0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: short random stalls, one long hold on request, none in the tail
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (hold_request) begin
					stall_left = LONG_HOLD;
					hold_request = 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 4);
				end
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// both channels are sampled on the rising edge; events are noted before results
	// so that a word arriving in the same cycle still meets its own expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (evt_ch.valid && evt_ch.ready)
				sb.note_event(evt_ch.opcode, evt_ch.note_key, evt_ch.now);
			if (res_ch.valid && res_ch.ready)
				sb.check_result({res_ch.action, res_ch.voice, res_ch.voice_key, res_ch.last});
			if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// offer one event word and hold it until taken, then maybe leave a short gap
	task automatic offer_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [TIME_W-1:0] stamp);
		int gap;
		@(negedge clk);
		evt_ch.valid <= 1'b1;
		evt_ch.opcode <= op;
		evt_ch.note_key <= key;
		evt_ch.now <= stamp;
		do @(posedge clk); while (!evt_ch.ready);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			evt_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// stop offering, wait for every outstanding word, then let the block settle
	task automatic drain_results();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (sb.due_words.size() != 0) @(posedge clk);
		repeat (2 * VOICES + 4) @(posedge clk);
	endtask

	// only called with the block idle
	task automatic write_release_mode(input bit mode);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.envelope_mode = mode;
	endtask

	initial begin
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		int pick;

		sb = new();
		evt_ch.valid = 1'b0;
		evt_ch.opcode = OP_PRESS;
		evt_ch.note_key = '0;
		evt_ch.now = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// envelope release mode, written even though it is the reset value
		write_release_mode(1'b1);

		// key zero matches a free voice and takes it over
		offer_word(OP_PRESS, 7'd0, 48'd0);
		// highest playable key at the top time stamp
		offer_word(OP_PRESS, KEY_LIMIT - 7'd1, '1);
		// keys at and above the limit are ignored
		offer_word(OP_PRESS, KEY_LIMIT, 48'd1);
		offer_word(OP_PRESS, 7'h7F, 48'd1);
		// same key again while held
		offer_word(OP_PRESS, KEY_LIMIT - 7'd1, 48'd2);
		// release of a key nobody holds
		offer_word(OP_RELEASE, 7'h2A, 48'd3);
		offer_word(OP_RELEASE, KEY_LIMIT - 7'd1, 48'd4);
		// released voice still carries the key, so it is reused
		offer_word(OP_PRESS, KEY_LIMIT - 7'd1, 48'd5);
		offer_word(OP_UNDEF, 7'h55, 48'd6);
		offer_word(OP_PRESS, 7'd0, 48'd7);
		// fill the rest with stamps running backwards
		for (int k = 1; k <= 6; k++)
			offer_word(OP_PRESS, 7'h10 + 7'(k), 48'(100 - 10 * k));
		// every voice held: steal the one pressed earliest
		offer_word(OP_PRESS, 7'h30, 48'd200);
		offer_word(OP_ALL_OFF, 7'd0, 48'd300);
		offer_word(OP_RELEASE, 7'h11, 48'd301);
		offer_word(OP_PRESS, 7'h11, 48'd302);

		// immediate clear mode
		drain_results();
		write_release_mode(1'b0);
		offer_word(OP_PRESS, 7'h22, 48'd400);
		offer_word(OP_RELEASE, 7'h22, 48'd401);
		// the cleared voice now carries key zero
		offer_word(OP_PRESS, 7'd0, 48'd402);
		offer_word(OP_ALL_OFF, 7'h7F, 48'd403);

		frame = 48'd1000;
		// random phases alternate the release mode
		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			write_release_mode(phase % 2 == 0);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (phase % 2 == 0 && n == 30)
					hold_request = 1'b1;
				if (phase == 1 && n == 60)
					drain_results();
				if (phase == 3 && n == TAIL_START)
					quiet_tail = 1'b1;

				// mostly small key pool so releases match and voices get stolen
				key = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 11));
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					op = OP_PRESS;
				end else if (pick < 80) begin
					op = OP_RELEASE;
				end else if (pick < 90) begin
					op = OP_ALL_OFF;
				end else if (pick < 95) begin
					op = OP_PRESS;
					key = 7'($urandom_range(KEY_LIMIT, 127));
				end else begin
					op = OP_UNDEF;
				end

				// time mostly creeps forward, with ties, and now and then jumps anywhere
				if ($urandom_range(0, 9) == 0)
					frame = {16'($urandom), $urandom};
				else
					frame = frame + 48'($urandom_range(0, 40));

				offer_word(op, key, frame);
			end
		end

		drain_results();
		if (sb.bad_words == 0 && sb.due_words.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			if (sb.due_words.size() != 0)
				$display("%0d expected words never arrived", sb.due_words.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
